// ===== hw/rtl/npt_pkg.sv =====
// ----------------------------------------------------------------------------
// npt_pkg
// Types and constants shared by the nearest piece table modules.
// ----------------------------------------------------------------------------
package npt_pkg;

    localparam int POS_W  = 24;
    localparam int TAG_W  = 32;
    localparam int DIST_W = 50;
    localparam int THR_W  = 46;
    localparam int RAD_W  = 23;

    // pipeline depth from read issue to rank update
    localparam int DRAIN_CYC = 4;

    localparam logic signed [POS_W:0]   LIGHT_LIFT = 25'sd243;
    localparam logic signed [POS_W:0]   POS_MAX_X  = 25'sd8388607;
    localparam logic [RAD_W-1:0]        RADIUS_RST = 23'd11520;

    localparam logic [1:0] KIND_PLACE   = 2'd0;
    localparam logic [1:0] KIND_REMOVE  = 2'd1;
    localparam logic [1:0] KIND_LIGHTS  = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    localparam logic [1:0] PT_TORCH = 2'd2;

    localparam logic [2:0] ST_PLACED   = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NONE     = 3'd3;
    localparam logic [2:0] ST_LIGHT    = 3'd4;
    localparam logic [2:0] ST_NO_LIGHT = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } fsm_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [TAG_W-1:0]        tag;
    } piece_t;

    // travels with each slot read down the pipeline
    typedef struct packed {
        logic vld;
        logic occ;
    } scan_t;

    typedef struct packed {
        logic [DIST_W-1:0]       d;
        logic [TAG_W-1:0]        tag;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } light_t;

endpackage

// ===== hw/rtl/nearest_piece_table.sv =====
// ----------------------------------------------------------------------------
// nearest_piece_table
// Table of placed pieces with place, remove-nearest and nearest-lights.
// ----------------------------------------------------------------------------
// One item at a time. Place walks the occupancy bits one slot a cycle and
// stops at the first free slot or at the last slot when the table is full.
// Remove and nearest-lights read every slot from the piece memory, one per
// cycle, through the distance pipeline. The single read port of the piece
// memory sets that read rate. The input is taken again as soon as the last
// result sits in the output register.
module nearest_piece_table
    import npt_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int MAX_LIGHTS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [1:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_kind,
    input  logic [1:0]               s_piece_type,
    input  logic signed [POS_W-1:0]  s_pos_x,
    input  logic signed [POS_W-1:0]  s_pos_y,
    input  logic signed [POS_W-1:0]  s_pos_z,
    input  logic [RAD_W-1:0]         s_max_dist,
    input  logic [3:0]               s_max_count,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_status,
    output logic [TAG_W-1:0]         m_piece_id,
    output logic signed [POS_W-1:0]  m_light_x,
    output logic signed [POS_W-1:0]  m_light_y,
    output logic signed [POS_W-1:0]  m_light_z,
    output logic                     m_last
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(MAX_LIGHTS+1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    fsm_t                     state_reg, state_next;
    logic [RAD_W-1:0]         radius_reg;
    logic [SLOTS-1:0]         slot_valid_reg;
    logic [TAG_W-1:0]         next_id_reg;
    logic [1:0]               kind_reg;
    logic [1:0]               ptype_reg;
    logic signed [POS_W-1:0]  qx_reg, qy_reg, qz_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [THR_W-1:0]         thr_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [1:0]               drain_reg;
    logic [CNT_W-1:0]         res_idx_reg;
    logic                     pend_full_reg;
    logic [TAG_W-1:0]         pend_id_reg;
    logic                     clr_reg;

    logic                     m_valid_reg;
    logic [2:0]               m_status_reg;
    logic [TAG_W-1:0]         m_id_reg;
    logic signed [POS_W-1:0]  m_x_reg, m_y_reg, m_z_reg;
    logic                     m_last_reg;

    logic                     accept, out_free, scan_last, place_free;
    logic                     place_we, issue, load, clr;
    logic [2:0]               o_status;
    logic [TAG_W-1:0]         o_id;
    logic signed [POS_W-1:0]  o_x, o_y, o_z;
    logic                     o_last;
    logic signed [POS_W:0]    lift_y;
    logic [CNT_W-1:0]         cnt_sat;
    logic [RAD_W-1:0]         mul_a;

    piece_t                   wdata;
    scan_t                    rd_req, st_tag, ds_tag;
    logic [IDX_W-1:0]         st_slot, ds_slot;
    piece_t                   st_data, ds_piece;
    logic [DIST_W-1:0]        ds_d;
    logic                     found;
    logic [IDX_W-1:0]         best_slot;
    logic [TAG_W-1:0]         best_tag;
    logic [CNT_W-1:0]         n;
    light_t                   lst [MAX_LIGHTS];
    light_t                   cur;

    // configuration port
    assign pready = 1'b1;
    assign prdata = {{(32-RAD_W){1'b0}}, radius_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RST;
        end else if (psel && penable && pwrite) begin
            radius_reg <= pwdata[RAD_W-1:0];
        end
    end

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign scan_last  = idx_reg == LAST_IDX;
    assign place_free = !slot_valid_reg[idx_reg];
    assign cnt_sat    = (32'(s_max_count) > MAX_LIGHTS) ? CNT_W'(MAX_LIGHTS)
                                                        : CNT_W'(s_max_count);
    assign mul_a      = (s_kind == KIND_LIGHTS) ? radius_reg : s_max_dist;
    assign cur        = lst[res_idx_reg[$clog2(MAX_LIGHTS > 1 ? MAX_LIGHTS : 2)-1:0]];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && s_kind != KIND_IGNORED) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (kind_reg == KIND_PLACE) begin
                    if (place_free || scan_last) begin
                        state_next = S_RESULT;
                    end
                end else if (scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (drain_reg == 2'(DRAIN_CYC - 1)) begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free && o_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready  = 1'b0;
        clr      = 1'b0;
        place_we = 1'b0;
        issue    = 1'b0;
        load     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                clr     = accept;
            end
            S_SCAN: begin
                place_we = kind_reg == KIND_PLACE && place_free;
                issue    = kind_reg != KIND_PLACE;
            end
            S_RESULT: begin
                load = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // result of the current item
    always_comb begin
        o_status = ST_NONE;
        o_id     = '0;
        o_x      = '0;
        o_y      = '0;
        o_z      = '0;
        o_last   = 1'b1;
        lift_y   = {cur.y[POS_W-1], cur.y} + LIGHT_LIFT;
        case (kind_reg)
            KIND_PLACE: begin
                o_status = pend_full_reg ? ST_FULL : ST_PLACED;
                o_id     = pend_full_reg ? '0 : pend_id_reg;
            end
            KIND_REMOVE: begin
                o_status = found ? ST_REMOVED : ST_NONE;
                o_id     = found ? best_tag : '0;
            end
            KIND_LIGHTS: begin
                if (n == '0) begin
                    o_status = ST_NO_LIGHT;
                end else begin
                    o_status = ST_LIGHT;
                    o_x      = cur.x;
                    o_z      = cur.z;
                    o_y      = (lift_y > POS_MAX_X) ? POS_MAX_X[POS_W-1:0]
                                                    : lift_y[POS_W-1:0];
                    o_last   = res_idx_reg == n - 1'b1;
                end
            end
            default: begin
                o_status = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            slot_valid_reg <= '0;
            next_id_reg    <= 32'd1;
            m_valid_reg    <= 1'b0;
            clr_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            // rank clears in the cycle after accept, once the new threshold is held
            clr_reg   <= clr;
            if (place_we) begin
                slot_valid_reg[idx_reg] <= 1'b1;
                next_id_reg             <= next_id_reg + 1'b1;
            end
            if (load && kind_reg == KIND_REMOVE && found) begin
                slot_valid_reg[best_slot] <= 1'b0;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= s_kind;
            ptype_reg <= s_piece_type;
            qx_reg    <= s_pos_x;
            qy_reg    <= s_pos_y;
            qz_reg    <= s_pos_z;
            cnt_reg   <= cnt_sat;
            thr_reg   <= mul_a * mul_a;
            idx_reg   <= '0;
            res_idx_reg <= '0;
        end else if (state_reg == S_SCAN && !scan_last) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (state_reg == S_SCAN) begin
            drain_reg     <= '0;
            pend_full_reg <= !place_free;
            pend_id_reg   <= next_id_reg;
        end else if (state_reg == S_DRAIN) begin
            drain_reg <= drain_reg + 1'b1;
        end
        if (load) begin
            res_idx_reg  <= res_idx_reg + 1'b1;
            m_status_reg <= o_status;
            m_id_reg     <= o_id;
            m_x_reg      <= o_x;
            m_y_reg      <= o_y;
            m_z_reg      <= o_z;
            m_last_reg   <= o_last;
        end
    end

    assign wdata  = '{kind: ptype_reg, x: qx_reg, y: qy_reg, z: qz_reg, tag: next_id_reg};
    assign rd_req = '{vld: issue, occ: slot_valid_reg[idx_reg]};

    npt_store #(.SLOTS(SLOTS)) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (place_we),
        .waddr   (idx_reg),
        .wdata   (wdata),
        .rd_req  (rd_req),
        .raddr   (idx_reg),
        .rd_tag  (st_tag),
        .rd_slot (st_slot),
        .rd_data (st_data)
    );

    npt_dist #(.SLOTS(SLOTS)) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_tag    (st_tag),
        .in_slot   (st_slot),
        .in_piece  (st_data),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .qz        (qz_reg),
        .out_tag   (ds_tag),
        .out_slot  (ds_slot),
        .out_piece (ds_piece),
        .out_d     (ds_d)
    );

    npt_rank #(.SLOTS(SLOTS), .MAX_LIGHTS(MAX_LIGHTS)) u_rank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clr         (clr_reg),
        .mode_lights (kind_reg == KIND_LIGHTS),
        .cnt         (cnt_reg),
        .thr         (thr_reg),
        .in_tag      (ds_tag),
        .in_slot     (ds_slot),
        .in_piece    (ds_piece),
        .in_d        (ds_d),
        .found       (found),
        .best_slot   (best_slot),
        .best_tag    (best_tag),
        .n           (n),
        .lst         (lst)
    );

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_piece_id = m_id_reg;
    assign m_light_x  = m_x_reg;
    assign m_light_y  = m_y_reg;
    assign m_light_z  = m_z_reg;
    assign m_last     = m_last_reg;

    // no slot beat may still be in flight once the block takes a new item
    a_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !ds_tag.vld && !st_tag.vld)
        else $error("scan beat in flight while idle");

    a_list_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RESULT |-> n <= cnt_reg)
        else $error("light list longer than requested count");

    a_place_one: assert property (@(posedge aclk) disable iff (!aresetn)
        place_we |=> $countones(slot_valid_reg) ==
                     $past($countones(slot_valid_reg)) + 1)
        else $error("place did not occupy exactly one slot");

endmodule

// ===== hw/rtl/npt_store.sv =====
// ----------------------------------------------------------------------------
// npt_store
// Piece memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module npt_store
    import npt_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      we,
    input  logic [$clog2(SLOTS)-1:0]  waddr,
    input  piece_t                    wdata,
    input  scan_t                     rd_req,
    input  logic [$clog2(SLOTS)-1:0]  raddr,
    output scan_t                     rd_tag,
    output logic [$clog2(SLOTS)-1:0]  rd_slot,
    output piece_t                    rd_data
);

    piece_t mem [SLOTS];

    scan_t                     tag_reg;
    logic [$clog2(SLOTS)-1:0]  slot_reg;
    piece_t                    data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        data_reg <= mem[raddr];
        slot_reg <= raddr;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= rd_req;
        end
    end

    assign rd_tag  = tag_reg;
    assign rd_slot = slot_reg;
    assign rd_data = data_reg;

endmodule

// ===== hw/rtl/npt_dist.sv =====
// ----------------------------------------------------------------------------
// npt_dist
// Squared distance pipeline: difference, square, sum, one stage each.
// ----------------------------------------------------------------------------
module npt_dist
    import npt_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  scan_t                     in_tag,
    input  logic [$clog2(SLOTS)-1:0]  in_slot,
    input  piece_t                    in_piece,
    input  logic signed [POS_W-1:0]   qx,
    input  logic signed [POS_W-1:0]   qy,
    input  logic signed [POS_W-1:0]   qz,
    output scan_t                     out_tag,
    output logic [$clog2(SLOTS)-1:0]  out_slot,
    output piece_t                    out_piece,
    output logic [DIST_W-1:0]         out_d
);

    scan_t                     t1_reg, t2_reg, t3_reg;
    logic [$clog2(SLOTS)-1:0]  s1_reg, s2_reg, s3_reg;
    piece_t                    p1_reg, p2_reg, p3_reg;
    logic signed [POS_W:0]     dx_reg, dy_reg, dz_reg;
    logic [DIST_W-1:0]         sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0]         d_reg;

    always_ff @(posedge aclk) begin
        dx_reg <= {in_piece.x[POS_W-1], in_piece.x} - {qx[POS_W-1], qx};
        dy_reg <= {in_piece.y[POS_W-1], in_piece.y} - {qy[POS_W-1], qy};
        dz_reg <= {in_piece.z[POS_W-1], in_piece.z} - {qz[POS_W-1], qz};
        sx_reg <= $unsigned(DIST_W'(dx_reg) * DIST_W'(dx_reg));
        sy_reg <= $unsigned(DIST_W'(dy_reg) * DIST_W'(dy_reg));
        sz_reg <= $unsigned(DIST_W'(dz_reg) * DIST_W'(dz_reg));
        d_reg  <= sx_reg + sy_reg + sz_reg;
        s1_reg <= in_slot;
        s2_reg <= s1_reg;
        s3_reg <= s2_reg;
        p1_reg <= in_piece;
        p2_reg <= p1_reg;
        p3_reg <= p2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
        end else begin
            t1_reg <= in_tag;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
        end
    end

    assign out_tag   = t3_reg;
    assign out_slot  = s3_reg;
    assign out_piece = p3_reg;
    assign out_d     = d_reg;

endmodule

// ===== hw/rtl/npt_rank.sv =====
// ----------------------------------------------------------------------------
// npt_rank
// Keeps the best remove candidate and a sorted list of nearest torches.
// ----------------------------------------------------------------------------
module npt_rank
    import npt_pkg::*;
#(
    parameter int SLOTS      = 64,
    parameter int MAX_LIGHTS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               clr,
    input  logic                               mode_lights,
    input  logic [$clog2(MAX_LIGHTS+1)-1:0]    cnt,
    input  logic [THR_W-1:0]                   thr,
    input  scan_t                              in_tag,
    input  logic [$clog2(SLOTS)-1:0]           in_slot,
    input  piece_t                             in_piece,
    input  logic [DIST_W-1:0]                  in_d,
    output logic                               found,
    output logic [$clog2(SLOTS)-1:0]           best_slot,
    output logic [TAG_W-1:0]                   best_tag,
    output logic [$clog2(MAX_LIGHTS+1)-1:0]    n,
    output light_t                             lst [MAX_LIGHTS]
);

    localparam int CNT_W = $clog2(MAX_LIGHTS+1);

    logic                      found_reg;
    logic [$clog2(SLOTS)-1:0]  bslot_reg;
    logic [TAG_W-1:0]          btag_reg;
    logic [DIST_W-1:0]         bd_reg;
    logic [CNT_W-1:0]          n_reg, n_next;
    light_t                    lst_reg [MAX_LIGHTS];

    logic [MAX_LIGHTS-1:0]     le;
    logic [CNT_W-1:0]          p;
    logic                      hit, ins, cand;
    light_t                    new_ent;

    assign new_ent = '{d: in_d, tag: in_piece.tag, x: in_piece.x, y: in_piece.y,
                       z: in_piece.z};

    always_comb begin
        p = '0;
        for (int i = 0; i < MAX_LIGHTS; i++) begin
            le[i] = (CNT_W'(i) < n_reg) &&
                    ((lst_reg[i].d < in_d) ||
                     (lst_reg[i].d == in_d && lst_reg[i].tag <= in_piece.tag));
            p = p + CNT_W'(le[i]);
        end
        hit  = in_tag.vld && in_tag.occ && in_piece.kind == PT_TORCH &&
               in_d < DIST_W'(thr);
        ins  = mode_lights && hit && p < cnt;
        n_next = (ins && n_reg < cnt) ? n_reg + 1'b1 : n_reg;
        cand = !mode_lights && in_tag.vld && in_tag.occ &&
               (in_d < bd_reg ||
                (found_reg && in_d == bd_reg && in_piece.tag < btag_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            n_reg     <= '0;
        end else if (clr) begin
            found_reg <= 1'b0;
            n_reg     <= '0;
        end else begin
            if (cand) begin
                found_reg <= 1'b1;
            end
            n_reg <= n_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr) begin
            bd_reg <= DIST_W'(thr);
        end else if (cand) begin
            bd_reg    <= in_d;
            bslot_reg <= in_slot;
            btag_reg  <= in_piece.tag;
        end
    end

    for (genvar g = 0; g < MAX_LIGHTS; g++) begin : g_ent
        always_ff @(posedge aclk) begin
            if (ins && !le[g]) begin
                if (g == 0) begin
                    lst_reg[g] <= new_ent;
                end else if (le[(g > 0) ? g - 1 : 0]) begin
                    lst_reg[g] <= new_ent;
                end else begin
                    lst_reg[g] <= lst_reg[(g > 0) ? g - 1 : 0];
                end
            end
        end
        assign lst[g] = lst_reg[g];
    end

    assign found     = found_reg;
    assign best_slot = bslot_reg;
    assign best_tag  = btag_reg;
    assign n         = n_reg;

endmodule

// ===== dv/nearest_piece_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_piece_table_tb
// Drives place, remove-nearest and nearest-lights beats into the piece table
// under random sender bursts and receiver stalls. Each accepted beat is run
// through a local table model and every result beat is compared per field.
// ----------------------------------------------------------------------------
module nearest_piece_table_tb;
    import npt_pkg::*;

    localparam int NSLOT      = 64;
    localparam int NLIGHT     = 8;
    localparam int DRAIN_WAIT = NSLOT + 40;
    localparam int CYCLE_CAP  = 600000;

    typedef struct {
        logic [1:0]              kind;
        logic [1:0]              ptype;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [RAD_W-1:0]        md;
        logic [3:0]              cnt;
    } op_t;

    typedef struct {
        logic [2:0]              status;
        logic [TAG_W-1:0]        id;
        logic signed [POS_W-1:0] lx;
        logic signed [POS_W-1:0] ly;
        logic signed [POS_W-1:0] lz;
        logic                    last;
    } res_t;

    typedef struct {
        op_t              op;
        bit               fixed;
        logic [2:0]       st;
        logic [TAG_W-1:0] id;
    } row_t;

    logic aclk, aresetn;
    logic psel, penable, pwrite, pready;
    logic [1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic s_valid, s_ready, m_valid, m_ready, m_last;
    logic [1:0] s_kind, s_piece_type;
    logic signed [POS_W-1:0] s_pos_x, s_pos_y, s_pos_z;
    logic [RAD_W-1:0] s_max_dist;
    logic [3:0] s_max_count;
    logic [2:0] m_status;
    logic [TAG_W-1:0] m_piece_id;
    logic signed [POS_W-1:0] m_light_x, m_light_y, m_light_z;

    nearest_piece_table i_dut (.*);

    // local copy of the table
    bit                      occ [NSLOT];
    logic [1:0]              tkind [NSLOT];
    logic signed [POS_W-1:0] tx [NSLOT];
    logic signed [POS_W-1:0] ty [NSLOT];
    logic signed [POS_W-1:0] tz [NSLOT];
    logic [TAG_W-1:0]        ttag [NSLOT];
    logic [TAG_W-1:0]        id_ctr;
    logic [RAD_W-1:0]        radius;

    res_t pending_results[$];
    int   mismatch_cnt;
    int   cycle_cnt;
    int   hold_cycles;
    bit   fix_en;
    logic [2:0] fix_st;
    logic [TAG_W-1:0] fix_id;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint sq_dist(int s, op_t o);
        longint dx, dy, dz;
        dx = longint'(tx[s]) - longint'(o.x);
        dy = longint'(ty[s]) - longint'(o.y);
        dz = longint'(tz[s]) - longint'(o.z);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    function automatic res_t mk_res(logic [2:0] st, logic [TAG_W-1:0] id);
        res_t r;
        r.status = st; r.id = id; r.lx = '0; r.ly = '0; r.lz = '0; r.last = 1'b1;
        return r;
    endfunction

    // applies one beat to the local table and returns the result beats
    function automatic void compute_results(op_t o, ref res_t out[$]);
        longint best, d, r2;
        longint ld [NLIGHT];
        int ls [NLIGHT];
        int n, p, cnt, bs;
        bit found;
        res_t r;
        longint yl;
        out.delete();
        if (o.kind == KIND_PLACE) begin
            for (int s = 0; s < NSLOT; s++) begin
                if (!occ[s]) begin
                    occ[s] = 1'b1; tkind[s] = o.ptype;
                    tx[s] = o.x; ty[s] = o.y; tz[s] = o.z; ttag[s] = id_ctr;
                    out = {out, mk_res(ST_PLACED, id_ctr)};
                    id_ctr = id_ctr + 1;
                    return;
                end
            end
            out = {out, mk_res(ST_FULL, '0)};
        end else if (o.kind == KIND_REMOVE) begin
            best = longint'(o.md) * longint'(o.md);
            found = 0; bs = 0;
            for (int s = 0; s < NSLOT; s++) begin
                if (!occ[s]) continue;
                d = sq_dist(s, o);
                if (d < best || (found && d == best && ttag[s] < ttag[bs])) begin
                    best = d; bs = s; found = 1;
                end
            end
            if (!found) out = {out, mk_res(ST_NONE, '0)};
            else begin
                occ[bs] = 1'b0;
                out = {out, mk_res(ST_REMOVED, ttag[bs])};
            end
        end else if (o.kind == KIND_LIGHTS) begin
            r2 = longint'(radius) * longint'(radius);
            cnt = (o.cnt > NLIGHT) ? NLIGHT : int'(o.cnt);
            n = 0;
            for (int s = 0; s < NSLOT && cnt > 0; s++) begin
                if (!occ[s] || tkind[s] != PT_TORCH) continue;
                d = sq_dist(s, o);
                if (!(d < r2)) continue;
                p = n;
                while (p > 0 && (ld[p-1] > d || (ld[p-1] == d && ttag[ls[p-1]] > ttag[s])))
                    p--;
                if (p >= cnt) continue;
                if (n < cnt) n++;
                for (int i = n - 1; i > p; i--) begin
                    ld[i] = ld[i-1]; ls[i] = ls[i-1];
                end
                ld[p] = d; ls[p] = s;
            end
            if (n == 0) out = {out, mk_res(ST_NO_LIGHT, '0)};
            for (int i = 0; i < n; i++) begin
                yl = longint'(ty[ls[i]]) + 243;
                if (yl > 8388607) yl = 8388607;
                r.status = ST_LIGHT; r.id = '0;
                r.lx = tx[ls[i]]; r.ly = yl[POS_W-1:0]; r.lz = tz[ls[i]];
                r.last = (i == n - 1);
                out = {out, r};
            end
        end
    endfunction

    // monitor: input beats feed the model, output beats are checked
    always @(posedge aclk) begin
        op_t o;
        res_t got, want;
        res_t beats[$];
        if (aresetn && s_valid && s_ready) begin
            o.kind = s_kind; o.ptype = s_piece_type;
            o.x = s_pos_x; o.y = s_pos_y; o.z = s_pos_z;
            o.md = s_max_dist; o.cnt = s_max_count;
            compute_results(o, beats);
            if (fix_en) begin
                beats.delete();
                beats = {beats, mk_res(fix_st, fix_id)};
            end
            foreach (beats[i]) pending_results = {pending_results, beats[i]};
        end
        if (aresetn && m_valid && m_ready) begin
            got.status = m_status; got.id = m_piece_id;
            got.lx = m_light_x; got.ly = m_light_y; got.lz = m_light_z;
            got.last = m_last;
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected result beat st=%0d", m_status);
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch exp st=%0d id=%0d l=%0d,%0d,%0d last=%0d | got st=%0d id=%0d l=%0d,%0d,%0d last=%0d",
                            want.status, want.id, want.lx, want.ly, want.lz, want.last,
                            got.status, got.id, got.lx, got.ly, got.lz, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver stall pattern, with an optional long hold-off
    initial begin
        int mode;
        int left;
        m_ready = 1'b0;
        mode = 0; left = 0;
        forever begin
            @(posedge aclk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 120);
            end
            left--;
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 0);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= cycle_cnt[0];
                endcase
            end
        end
    end

    // caller is at a clock edge; returns at the edge of acceptance
    task automatic send_op(op_t o, bit fx, logic [2:0] st, logic [TAG_W-1:0] id);
        s_valid <= 1'b1;
        s_kind <= o.kind; s_piece_type <= o.ptype;
        s_pos_x <= o.x; s_pos_y <= o.y; s_pos_z <= o.z;
        s_max_dist <= o.md; s_max_count <= o.cnt;
        fix_en <= fx; fix_st <= st; fix_id <= id;
        do @(posedge aclk); while (!s_ready);
    endtask

    int burst_left;
    bit bursty;

    task automatic after_beat();
        int gap;
        if (!bursty) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 20);
        s_valid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        // let the monitor log the last accepted beat first
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_radius(logic [RAD_W-1:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 2'd0;
        pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        radius = v;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic op_t mk_op(logic [1:0] k, int pt, int x, int y, int z,
                                  int md, int cnt);
        op_t o;
        o.kind = k; o.ptype = pt[1:0]; o.x = x[POS_W-1:0]; o.y = y[POS_W-1:0];
        o.z = z[POS_W-1:0]; o.md = md[RAD_W-1:0]; o.cnt = cnt[3:0];
        return o;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos(bit wide);
        if (wide) return POS_W'($urandom);
        return POS_W'($urandom_range(0, 8191) - 4096);
    endfunction

    function automatic op_t rand_op(int place_pct, bit wide);
        op_t o;
        int r;
        r = $urandom_range(0, 99);
        if (r < place_pct) o.kind = KIND_PLACE;
        else if (r < place_pct + (95 - place_pct) / 2) o.kind = KIND_REMOVE;
        else if (r < 95) o.kind = KIND_LIGHTS;
        else o.kind = KIND_IGNORED;
        o.ptype = ($urandom_range(0, 2) == 0) ? PT_TORCH : 2'($urandom);
        o.x = rand_pos(wide); o.y = rand_pos(wide); o.z = rand_pos(wide);
        if ($urandom_range(0, 4) == 0) o.md = RAD_W'($urandom);
        else o.md = RAD_W'($urandom_range(0, 6000));
        o.cnt = 4'($urandom);
        return o;
    endfunction

    row_t rows[$];

    task automatic add_row(op_t o, int fx, int st, int id);
        row_t r;
        r.op = o; r.fixed = (fx != 0); r.st = st[2:0]; r.id = TAG_W'(id);
        rows = {rows, r};
    endtask

    initial begin
        logic [RAD_W-1:0] radii [5];
        op_t o;
        aresetn = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_kind = '0; s_piece_type = '0;
        s_pos_x = '0; s_pos_y = '0; s_pos_z = '0; s_max_dist = '0; s_max_count = '0;
        fix_en = 0; fix_st = '0; fix_id = '0;
        mismatch_cnt = 0; cycle_cnt = 0; hold_cycles = 0;
        burst_left = 0; bursty = 1;
        foreach (occ[i]) occ[i] = 0;
        id_ctr = 1;
        radius = RADIUS_RST;

        // empty table, extremes, ties, saturation, ignored kind
        add_row(mk_op(KIND_REMOVE, 0, 0, 0, 0, 8388607, 0), 1, ST_NONE, 0);
        add_row(mk_op(KIND_LIGHTS, 0, 0, 0, 0, 0, 8), 1, ST_NO_LIGHT, 0);
        add_row(mk_op(KIND_PLACE, 0, 8388607, 8388607, 8388607, 0, 0), 1, ST_PLACED, 1);
        add_row(mk_op(KIND_PLACE, PT_TORCH, -8388608, -8388608, -8388608, 0, 0),
                1, ST_PLACED, 2);
        add_row(mk_op(KIND_PLACE, PT_TORCH, 0, 0, 0, 0, 0), 1, ST_PLACED, 3);
        add_row(mk_op(KIND_PLACE, PT_TORCH, 0, 8388600, 0, 0, 0), 1, ST_PLACED, 4);
        add_row(mk_op(KIND_PLACE, 3, 0, 0, 0, 0, 0), 1, ST_PLACED, 5);
        add_row(mk_op(KIND_PLACE, PT_TORCH, 256, 0, 0, 0, 0), 1, ST_PLACED, 6);
        add_row(mk_op(KIND_PLACE, PT_TORCH, -256, 0, 0, 0, 0), 1, ST_PLACED, 7);
        add_row(mk_op(KIND_PLACE, 1, 0, 0, 512, 0, 0), 1, ST_PLACED, 8);
        add_row(mk_op(KIND_LIGHTS, 0, 0, 0, 0, 0, 8), 0, 0, 0);
        add_row(mk_op(KIND_LIGHTS, 0, 0, 0, 0, 0, 0), 1, ST_NO_LIGHT, 0);
        add_row(mk_op(KIND_LIGHTS, 0, 0, 0, 0, 0, 15), 0, 0, 0);
        add_row(mk_op(KIND_LIGHTS, 0, 0, 0, 0, 0, 1), 0, 0, 0);
        add_row(mk_op(KIND_LIGHTS, 0, 0, 8388607, 0, 0, 2), 0, 0, 0);
        add_row(mk_op(KIND_IGNORED, 3, -1, -1, -1, 8388607, 15), 0, 0, 0);
        add_row(mk_op(KIND_REMOVE, 0, 0, 0, 0, 0, 0), 1, ST_NONE, 0);
        add_row(mk_op(KIND_REMOVE, 0, 0, 0, 0, 1, 0), 1, ST_REMOVED, 3);
        add_row(mk_op(KIND_REMOVE, 0, 128, 0, 0, 1000, 0), 0, 0, 0);
        add_row(mk_op(KIND_REMOVE, 0, 8388607, 8388607, 8388607, 8388607, 0), 0, 0, 0);
        add_row(mk_op(KIND_REMOVE, 0, -8388608, -8388608, -8388608, 1, 0),
                1, ST_REMOVED, 2);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            send_op(rows[i].op, rows[i].fixed, rows[i].st, rows[i].id);
            after_beat();
        end
        drain();

        radii[0] = '0;
        radii[1] = 23'd8388607;
        radii[2] = 23'd2048;
        radii[3] = RAD_W'($urandom_range(500, 6000));
        radii[4] = RADIUS_RST;
        for (int ph = 0; ph < 5; ph++) begin
            set_radius(radii[ph]);
            bursty = (ph != 3);
            if (ph == 1) begin
                // fill the table past full, then search it
                for (int i = 0; i < 70; i++) begin
                    o = rand_op(100, 1'b0);
                    send_op(o, 1'b0, ST_PLACED, '0);
                    after_beat();
                end
            end
            if (ph == 2) hold_cycles = 500;
            for (int i = 0; i < 16; i++) begin
                o = rand_op(35, ($urandom_range(0, 5) == 0));
                send_op(o, 1'b0, ST_PLACED, '0);
                after_beat();
            end
            drain();
        end

        if (pending_results.size() != 0) mismatch_cnt++;
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
